FILE: rtl/pkbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbs_pkg: shared types for the peak element search block
// Sequencer states and the status bundle from the search unit.
// ----------------------------------------------------------------------------
package pkbs_pkg;

  // search sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,   // taking elements
    ST_A0,     // read element 0
    ST_A1,     // read element 1, capture element 0
    ST_AN1,    // read element n-1, compare first pair
    ST_AN2,    // read element n-2, capture element n-1
    ST_CMPE,   // compare last pair, set up interior range
    ST_MID,    // pick middle, read it
    ST_M1,     // read left neighbour, capture middle
    ST_M2,     // read right neighbour, compare left
    ST_M3,     // compare right, narrow range
    ST_OUT     // result held for the consumer
  } state_t;

  // what the search unit lets the load side accept
  typedef struct packed {
    logic accept_load;  // a non-final item may be stored
    logic accept_last;  // a final item may close the set
  } srch_status_t;

endpackage

FILE: rtl/pkbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbs_ram: generic simple dual port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pkbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pkbs_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbs_search: peak search sequencer
// Checks both ends of sets of two or more, then binary-searches the interior
// through one ram read port, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pkbs_search #(
  parameter int DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [$clog2(DEPTH+1)-1:0]     n,
  output logic                           rd_en,
  output logic [$clog2(DEPTH)-1:0]       rd_addr,
  input  logic [31:0]                    rd_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(DEPTH)-1:0]       peak_idx,
  output logic                           found,
  output pkbs_pkg::srch_status_t         status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  pkbs_pkg::state_t state, state_next;

  logic [CW-1:0] n_reg;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] m;
  logic [31:0]   x;
  logic          gt_left;

  logic [CW-1:0] mid;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] n_m2;
  logic [CW-1:0] m_m1;
  logic [CW-1:0] m_p1;
  logic          x_gt_rd;
  logic          rd_gt_x;
  logic          empty;

  // arithmetic on the range
  assign mid     = lo + ((hi - lo) >> 1);
  assign n_m1    = n_reg - ONE;
  assign n_m2    = n_reg - TWO;
  assign m_m1    = m - ONE;
  assign m_p1    = m + ONE;
  assign x_gt_rd = $signed(x) > $signed(rd_data);
  assign rd_gt_x = $signed(rd_data) > $signed(x);
  assign empty   = lo > hi;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkbs_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pkbs_pkg::ST_LOAD: begin
        if (start) begin
          state_next = (n <= ONE) ? pkbs_pkg::ST_OUT : pkbs_pkg::ST_A0;
        end
      end
      pkbs_pkg::ST_A0:   state_next = pkbs_pkg::ST_A1;
      pkbs_pkg::ST_A1:   state_next = pkbs_pkg::ST_AN1;
      pkbs_pkg::ST_AN1:  state_next = x_gt_rd ? pkbs_pkg::ST_OUT : pkbs_pkg::ST_AN2;
      pkbs_pkg::ST_AN2:  state_next = pkbs_pkg::ST_CMPE;
      pkbs_pkg::ST_CMPE: state_next = x_gt_rd ? pkbs_pkg::ST_OUT : pkbs_pkg::ST_MID;
      pkbs_pkg::ST_MID:  state_next = empty ? pkbs_pkg::ST_OUT : pkbs_pkg::ST_M1;
      pkbs_pkg::ST_M1:   state_next = pkbs_pkg::ST_M2;
      pkbs_pkg::ST_M2:   state_next = pkbs_pkg::ST_M3;
      pkbs_pkg::ST_M3: begin
        state_next = (gt_left && x_gt_rd) ? pkbs_pkg::ST_OUT : pkbs_pkg::ST_MID;
      end
      pkbs_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = pkbs_pkg::ST_LOAD;
        end
      end
      default: state_next = pkbs_pkg::ST_LOAD;
    endcase
  end

  // read requests and handshake outputs
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      pkbs_pkg::ST_A0: begin
        rd_en = 1'b1;
      end
      pkbs_pkg::ST_A1: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      pkbs_pkg::ST_AN1: begin
        rd_en   = 1'b1;
        rd_addr = n_m1[AW-1:0];
      end
      pkbs_pkg::ST_AN2: begin
        rd_en   = 1'b1;
        rd_addr = n_m2[AW-1:0];
      end
      pkbs_pkg::ST_MID: begin
        rd_en   = !empty;
        rd_addr = mid[AW-1:0];
      end
      pkbs_pkg::ST_M1: begin
        rd_en   = 1'b1;
        rd_addr = m_m1[AW-1:0];
      end
      pkbs_pkg::ST_M2: begin
        rd_en   = 1'b1;
        rd_addr = m_p1[AW-1:0];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  assign out_valid          = (state == pkbs_pkg::ST_OUT);
  assign status.accept_last = (state == pkbs_pkg::ST_LOAD);
  assign status.accept_load = (state == pkbs_pkg::ST_LOAD) || (state == pkbs_pkg::ST_OUT);

  // search datapath
  always_ff @(posedge clk) begin
    unique case (state)
      pkbs_pkg::ST_LOAD: begin
        if (start) begin
          n_reg    <= n;
          peak_idx <= '0;
          found    <= 1'b1;
        end
      end
      pkbs_pkg::ST_A1: begin
        x <= rd_data;
      end
      pkbs_pkg::ST_AN1: begin
        if (x_gt_rd) begin
          peak_idx <= '0;
          found    <= 1'b1;
        end
      end
      pkbs_pkg::ST_AN2: begin
        x <= rd_data;
      end
      pkbs_pkg::ST_CMPE: begin
        if (x_gt_rd) begin
          peak_idx <= n_m1[AW-1:0];
          found    <= 1'b1;
        end else begin
          lo <= ONE;
          hi <= n_m2;
        end
      end
      pkbs_pkg::ST_MID: begin
        if (empty) begin
          peak_idx <= '0;
          found    <= 1'b0;
        end else begin
          m <= mid;
        end
      end
      pkbs_pkg::ST_M1: begin
        x <= rd_data;
      end
      pkbs_pkg::ST_M2: begin
        gt_left <= x_gt_rd;
      end
      pkbs_pkg::ST_M3: begin
        if (gt_left && x_gt_rd) begin
          peak_idx <= m[AW-1:0];
          found    <= 1'b1;
        end else if (rd_gt_x) begin
          lo <= m_p1;
        end else begin
          hi <= m_m1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/peak_element_binary_search.sv
`timescale 1ns / 1ps
// Result: for a single-element set it is valid in the cycle after the final item;
//   otherwise the end checks decide it, or interior probes run until a peak
//   is found or the range empties.
// Throughput: one element per cycle while loading; items stall during the
//   search, and a final item also waits until the previous result is taken.
// Reset: synchronous, active high; clears the sequencer and element count only.
// ----------------------------------------------------------------------------
// peak_element_binary_search: peak element finder
// Stores a set of signed elements in a ram and reports one peak index per set.
// ----------------------------------------------------------------------------
module peak_element_binary_search #(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] element_value,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  peak_index,
  output logic        found
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE     = CW'(1);

  pkbs_pkg::srch_status_t status;

  logic [CW-1:0] count;
  logic          in_acc;
  logic          has_room;
  logic          start;
  logic [CW-1:0] n;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [AW-1:0] peak_idx;

  // input acceptance
  assign in_stall = !(status.accept_load && (status.accept_last || !is_last));
  assign in_acc   = in_valid && !in_stall;
  assign has_room = count < DEPTH_C;
  assign start    = in_acc && is_last;
  assign n        = has_room ? (count + ONE) : count;

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= '0;
    end else if (in_acc && has_room) begin
      count <= count + ONE;
    end
  end

  // element store
  pkbs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc && has_room),
    .waddr (count[AW-1:0]),
    .wdata (element_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // search sequencer
  pkbs_search #(
    .DEPTH (DEPTH)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .n         (n),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .peak_idx  (peak_idx),
    .found     (found),
    .status    (status)
  );

  // index narrowed or widened to the output field
  generate
    if (AW >= 10) begin : g_idx_cut
      assign peak_index = peak_idx[9:0];
    end else begin : g_idx_ext
      assign peak_index = {{(10 - AW){1'b0}}, peak_idx};
    end
  endgenerate

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("element count beyond store depth");

  a_no_peak_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> peak_index == 10'd0)
    else $error("no-peak result with nonzero index");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |=> !status.accept_last)
    else $error("final item did not start a search");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |-> !out_valid)
    else $error("final item taken while a result is pending");

endmodule

FILE: verif/peak_element_binary_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_element_binary_search_test: self-checking bench for the peak finder
// Streams element sets into the block and compares each reported peak with a
// local binary search over the same elements. Both sides idle at random, except while items 400 to 799 are sent.
// ----------------------------------------------------------------------------
module peak_element_binary_search_test;

  localparam int DEPTH = 1024;
  localparam int IDLE_PCT = 33;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } element_item_t;

  typedef struct {
    logic [9:0] index;
    logic       hit;
  } peak_result_t;

  typedef enum int {
    SHAPE_NOISE,     // full-range random values
    SHAPE_FLAT,      // few distinct values, many plateaus
    SHAPE_MOUNTAIN,  // rise then fall, peak inside
    SHAPE_WALK       // small random steps, ends forced inward
  } set_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] element_value = '0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  peak_index;
  logic        found;

  element_item_t     pending_elements[$];
  peak_result_t      peak_due[$];
  logic signed [31:0] held[DEPTH];
  int                held_count = 0;
  int                sent = 0;
  int                total_items = 0;
  int                errors = 0;
  element_item_t     next_item;
  peak_result_t      got_due;
  wire               steady = (sent >= 400) && (sent < 800);

  peak_element_binary_search #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element_value(element_value),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .peak_index   (peak_index),
    .found        (found)
  );

  // clock
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (errors < 100) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  // binary search for a peak among the first n held elements
  function automatic void predict_peak(input int n, output logic [9:0] idx,
                                       output logic hit);
    int lo;
    int hi;
    int mid;
    idx = '0;
    hit = 1'b1;
    if (n <= 1) return;
    if (held[0] > held[1]) return;
    if (held[n-1] > held[n-2]) begin
      idx = 10'(n - 1);
      return;
    end
    lo = 1;
    hi = n - 2;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (held[mid] > held[mid-1] && held[mid] > held[mid+1]) begin
        idx = 10'(mid);
        return;
      end
      if (held[mid+1] > held[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    idx = '0;
    hit = 1'b0;
  endfunction

  // store an accepted item and queue the peak that closes its set
  task automatic record_element(input logic [31:0] value, input logic last);
    peak_result_t res;
    if (held_count < DEPTH) begin
      held[held_count] = value;
      held_count++;
    end
    if (last) begin
      predict_peak(held_count, res.index, res.hit);
      peak_due.push_back(res);
      held_count = 0;
    end
  endtask

  task automatic push_set(input int vals[$]);
    element_item_t it;
    foreach (vals[i]) begin
      it.value = vals[i];
      it.last = (i == vals.size() - 1);
      pending_elements.push_back(it);
      total_items++;
    end
  endtask

  // build one set of n elements of the given shape, noise if a mountain or walk is under three long
  task automatic add_set(input set_shape_t shape, input int n);
    int vals[$];
    int base;
    int peak_pos;
    int v;
    base = int'($urandom) >>> 2;
    if (n < 3 && (shape == SHAPE_MOUNTAIN || shape == SHAPE_WALK)) shape = SHAPE_NOISE;
    peak_pos = (n >= 3) ? $urandom_range(1, n - 2) : 0;
    v = base;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_NOISE: begin
          v = int'($urandom);
        end
        SHAPE_FLAT: begin
          v = base + $urandom_range(0, 2);
        end
        SHAPE_MOUNTAIN: begin
          if (i > 0 && i <= peak_pos) v = v + $urandom_range(0, 50);
          else if (i > peak_pos) v = v - $urandom_range(0, 50);
        end
        default: begin
          if (i == 1) v = v + $urandom_range(0, 3);
          else if (i == n - 1) v = v - $urandom_range(0, 3);
          else if (i > 1) v = v + $urandom_range(0, 6) - 3;
        end
      endcase
      vals.push_back(v);
    end
    push_set(vals);
  endtask

  // input driver: hold a stalled item, otherwise present the next or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        record_element(element_value, is_last);
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_elements.size() > 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_item = pending_elements.pop_front();
          in_valid <= 1'b1;
          element_value <= next_item.value;
          is_last <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (peak_due.size() == 0) begin
        report_mismatch("result with no set pending");
      end else begin
        got_due = peak_due.pop_front();
        if (peak_index !== got_due.index)
          report_mismatch($sformatf("peak_index %0d, want %0d", peak_index, got_due.index));
        if (found !== got_due.hit)
          report_mismatch($sformatf("found %0b, want %0b", found, got_due.hit));
      end
    end
  end

  // stimulus and end of run
  initial begin
    int rand_items;
    int n;
    set_shape_t shape;
    int pick;
    bit over_done;
    rand_items = 0;
    over_done = 0;

    // single element
    push_set('{5});
    // first pair decides, extremes
    push_set('{32'h7fff_ffff, 32'h8000_0000});
    // last pair decides
    push_set('{32'h8000_0000, 32'h7fff_ffff});
    // two equal elements, no peak
    push_set('{7, 7});
    // interior peak
    push_set('{1, 5, 3});
    // plateau, range empties
    push_set('{4, 4, 4});
    // interior search, peak found at the first probe
    push_set('{0, 3, 9, 2, 1, 0});
    // last wins over a plateau of maxima
    push_set('{32'h7fff_ffff, 32'h7fff_ffff, -5, 32'h7fff_ffff});

    while (rand_items < RANDOM_ITEMS) begin
      if (!over_done && rand_items >= 150) begin
        // more than the store holds: the store fills, extra elements and the last dropped
        add_set(SHAPE_WALK, DEPTH + 6);
        rand_items += DEPTH + 6;
        over_done = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) shape = SHAPE_NOISE;
      else if (pick < 30) shape = SHAPE_FLAT;
      else if (pick < 65) shape = SHAPE_MOUNTAIN;
      else shape = SHAPE_WALK;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_set(shape, n);
      rand_items += n;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (sent < total_items) @(posedge clk);
    while (peak_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[peak_element_binary_search] OK");
    end else begin
      $display("[peak_element_binary_search] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("[peak_element_binary_search] ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/pkbs_pkg.sv
rtl/pkbs_ram.sv
rtl/pkbs_search.sv
rtl/peak_element_binary_search.sv
verif/peak_element_binary_search_test.sv
